[src/pbde_pkg.sv]
// ----------------------------------------------------------------------------
// pbde_pkg
// Shared types and constants of the polled button debounce events unit.
// ----------------------------------------------------------------------------
package pbde_pkg;

	localparam int MAX_BUTTONS = 8;
	localparam int BTN_IDX_W   = 3;
	localparam int LEVEL_W     = 8;
	localparam int HOLD_W      = 8;
	localparam int TIME_W      = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;

	localparam int DEF_NUM_BUTTONS      = 8;
	localparam int DEF_TICKS_PER_SECOND = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;

	typedef struct packed {
		logic [LEVEL_W-1:0] pin_levels;
		logic [TIME_W-1:0]  now_ticks;
	} in_item_t;

	typedef struct packed {
		logic [BTN_IDX_W-1:0] button_index;
		logic                 pressed;
		logic [TIME_W-1:0]    seconds_since_last;
		logic                 last_in_run;
	} out_item_t;

	typedef struct packed {
		logic              emit;
		logic [TIME_W-1:0] diff;
	} lane_res_t;

	typedef struct packed {
		logic [BTN_IDX_W-1:0] button_index;
		logic                 pressed;
		logic                 last_in_run;
	} ev_t;

endpackage

[src/pbde_lane.sv]
// ----------------------------------------------------------------------------
// pbde_lane
// Debounce state of one button: hold counter, accepted level, last event time.
// ----------------------------------------------------------------------------
module pbde_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          first_done,
	input  logic                          level,
	input  logic                          report,
	input  logic [pbde_pkg::HOLD_W-1:0]   thr,
	input  logic [pbde_pkg::TIME_W-1:0]   now,
	output pbde_pkg::lane_res_t           res
);

	logic [pbde_pkg::HOLD_W-1:0] cnt_q;
	logic                        acc_q;
	logic [pbde_pkg::TIME_W-1:0] last_q;
	logic                        count_up;
	logic                        change;

	assign count_up = first_done && (cnt_q < thr);
	assign change   = !count_up && (level != acc_q);

	assign res.emit = change && report;
	assign res.diff = now - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			acc_q  <= 1'b0;
			last_q <= '0;
		end else if (tick) begin
			if (count_up) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (change) begin
				cnt_q <= '0;
				acc_q <= level;
				if (report) begin
					last_q <= now;
				end
			end
		end
	end

endmodule

[src/pbde_merge.sv]
// ----------------------------------------------------------------------------
// pbde_merge
// Holds the events of one tick and hands them out lowest button first.
// ----------------------------------------------------------------------------
module pbde_merge #(
	parameter int NUM_BUTTONS = pbde_pkg::DEF_NUM_BUTTONS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [NUM_BUTTONS-1:0]      load_mask,
	input  logic [NUM_BUTTONS-1:0]      load_levels,
	input  logic [pbde_pkg::TIME_W-1:0] load_diff [NUM_BUTTONS],
	input  logic                        adv,
	output logic                        ev_valid,
	output pbde_pkg::ev_t               ev,
	output logic [pbde_pkg::TIME_W-1:0] ev_diff,
	output logic                        can_load
);

	localparam int IW = pbde_pkg::BTN_IDX_W;

	logic [NUM_BUTTONS-1:0]      mask_q;
	logic [NUM_BUTTONS-1:0]      levels_q;
	logic [pbde_pkg::TIME_W-1:0] diff_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]      pick;
	logic [NUM_BUTTONS-1:0]      rest;
	logic [IW-1:0]               idx;
	logic [pbde_pkg::TIME_W-1:0] dsel;

	// lowest pending button
	assign pick = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~pick;

	always_comb begin
		idx  = '0;
		dsel = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (pick[i]) begin
				idx  = idx | IW'(i);
				dsel = dsel | diff_q[i];
			end
		end
	end

	assign ev_valid        = |mask_q;
	assign ev.button_index = idx;
	assign ev.pressed      = |(pick & levels_q);
	assign ev.last_in_run  = (rest == '0);
	assign ev_diff         = dsel;
	assign can_load        = !ev_valid || ((rest == '0) && adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_mask;
		end else if (adv && ev_valid) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			levels_q <= load_levels;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				diff_q[i] <= load_diff[i];
			end
		end
	end

endmodule

[src/pbde_div.sv]
// ----------------------------------------------------------------------------
// pbde_div
// Two-stage pipeline: tick difference over ticks per second by reciprocal.
// ----------------------------------------------------------------------------
module pbde_div #(
	parameter int TICKS_PER_SECOND = pbde_pkg::DEF_TICKS_PER_SECOND
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  pbde_pkg::ev_t               in_ev,
	input  logic [pbde_pkg::TIME_W-1:0] in_dividend,
	output logic                        adv,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pbde_pkg::out_item_t         out_data
);

	localparam int TW = pbde_pkg::TIME_W;
	localparam int SH = $clog2(TICKS_PER_SECOND);
	localparam int MW = TW + 1;
	localparam int PW = TW + MW;
	// ceil(2^(TW+SH) / divisor) gives the exact quotient for every TW-bit dividend
	localparam logic [63:0]   SCALE   = 64'd1 << (TW + SH);
	localparam logic [63:0]   DIVISOR = 64'(TICKS_PER_SECOND);
	localparam logic [MW-1:0] RECIP   = MW'((SCALE + DIVISOR - 64'd1) / DIVISOR);

	logic                vld_s1;
	logic                vld_s2;
	pbde_pkg::ev_t       ev_s1;
	pbde_pkg::ev_t       ev_s2;
	logic [TW-1:0]       num_s1;
	logic [TW-1:0]       quot_s2;
	logic [PW-1:0]       prod;

	assign prod = PW'(num_s1) * PW'(RECIP);

	assign adv = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s1   <= in_ev;
			num_s1  <= in_dividend;
			ev_s2   <= ev_s1;
			quot_s2 <= TW'(prod >> (TW + SH));
		end
	end

	assign out_valid                   = vld_s2;
	assign out_data.button_index       = ev_s2.button_index;
	assign out_data.pressed            = ev_s2.pressed;
	assign out_data.seconds_since_last = quot_s2;
	assign out_data.last_in_run        = ev_s2.last_in_run;

endmodule

[src/polled_button_debounce_events_unit.sv]
// ----------------------------------------------------------------------------
// polled_button_debounce_events_unit
// Debounces up to eight polled buttons and reports accepted level changes.
// ----------------------------------------------------------------------------
// Each input item is one poll tick: raw pin levels and the tick time. One lane
// per button updates its hold counter, accepted level and last event time in
// the cycle the tick is accepted. The events of the tick are buffered and sent
// out lowest button first, one per cycle unless stalled, through a two-stage
// pipeline that divides the tick difference by a reciprocal multiplication.
// Throughput: a tick with no event is taken every cycle; after a tick with
// events the next tick is taken with the last of them, as the merge hands out
// one event per cycle while the divider advances.
// The first result of a tick passes the event buffer and both divider stages.
// A stalled receiver freezes the divider pipeline and the event buffer, and in
// turn the input channel; no result is dropped.
// Configuration is a plain write port and takes effect at once; write it only
// while no item is in flight. Out-of-range indexes are ignored.
// Reset clears all button state, the registers and the pipeline; the first
// tick after reset checks every button regardless of its hold counter.
// ----------------------------------------------------------------------------
module polled_button_debounce_events_unit #(
	parameter int NUM_BUTTONS      = pbde_pkg::DEF_NUM_BUTTONS,
	parameter int TICKS_PER_SECOND = pbde_pkg::DEF_TICKS_PER_SECOND
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pbde_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pbde_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [pbde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbde_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LW = pbde_pkg::LEVEL_W;
	localparam int HW = pbde_pkg::HOLD_W;
	localparam int TW = pbde_pkg::TIME_W;

	logic [LW-1:0]                   active_low_q;
	logic [LW-1:0]                   report_q;
	logic [pbde_pkg::CFG_DATA_W-1:0] hold_q;
	logic                            first_done_q;

	logic                   accept;
	logic [LW-1:0]          levels;
	pbde_pkg::lane_res_t    res    [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] emit_v;
	logic [TW-1:0]          diff_a [NUM_BUTTONS];

	logic                   adv;
	logic                   ev_valid;
	pbde_pkg::ev_t          ev;
	logic [TW-1:0]          ev_diff;

	assign accept = in_valid && in_ready;
	assign levels = in_data.pin_levels ^ active_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= '0;
			report_q     <= '0;
			hold_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pbde_pkg::CFG_ACTIVE_LOW: active_low_q <= cfg_data[LW-1:0];
				pbde_pkg::CFG_REPORT:     report_q     <= cfg_data[LW-1:0];
				pbde_pkg::CFG_HOLD:       hold_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_done_q <= 1'b0;
		end else if (accept) begin
			first_done_q <= 1'b1;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		pbde_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.tick       (accept),
			.first_done (first_done_q),
			.level      (levels[i]),
			.report     (report_q[i]),
			.thr        (hold_q[HW*i +: HW]),
			.now        (in_data.now_ticks),
			.res        (res[i])
		);
		assign emit_v[i] = res[i].emit;
		assign diff_a[i] = res[i].diff;
	end

	pbde_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.load_mask   (emit_v),
		.load_levels (levels[NUM_BUTTONS-1:0]),
		.load_diff   (diff_a),
		.adv         (adv),
		.ev_valid    (ev_valid),
		.ev          (ev),
		.ev_diff     (ev_diff),
		.can_load    (in_ready)
	);

	pbde_div #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (ev_valid),
		.in_ev       (ev),
		.in_dividend (ev_diff),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
